>>> design/lasc_pkg.sv
// Shared widths, register and opcode codes, and cell operand types of the alignment scorer.
package lasc_pkg;

  localparam int unsigned SYM_W     = 8;
  localparam int unsigned SCORE_W   = 14;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SCORE_W-1:0] CELL_MAX = 14'h3FFF;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_EXT  = 2'd3;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_REF   = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] match;
    logic [CFG_W-1:0] mism;
    logic [CFG_W-1:0] open;
    logic [CFG_W-1:0] ext;
  } score_cfg_t;

  typedef struct packed {
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] cg_old;
    logic               cg_valid;
    logic [SCORE_W-1:0] rg_old;
    logic               rg_valid;
    logic               sym_eq;
  } cell_in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] h;
    logic [SCORE_W-1:0] cg;
    logic [SCORE_W-1:0] rg;
  } cell_out_t;

endpackage

>>> design/lasc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lasc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/lasc_cell_unit.sv
// Shared cell arithmetic: gap updates, substitution, floor at zero and saturation.
module lasc_cell_unit (
  input  lasc_pkg::cell_in_t   cell_i,
  input  lasc_pkg::score_cfg_t cfg_i,
  output lasc_pkg::cell_out_t  cell_o
);
  import lasc_pkg::*;

  localparam int unsigned ACC_W = SCORE_W + 2;

  typedef logic signed [ACC_W-1:0] acc_t;

  function automatic acc_t ext_score(logic [SCORE_W-1:0] v);
    return acc_t'({2'b00, v});
  endfunction

  function automatic acc_t ext_cfg(logic [CFG_W-1:0] v);
    return acc_t'({{(ACC_W-CFG_W){1'b0}}, v});
  endfunction

  acc_t cg_cand;
  acc_t rg_cand;
  acc_t cg_max;
  acc_t rg_max;
  acc_t diag_sum;
  acc_t cg_term;
  acc_t rg_term;
  acc_t best;

  always_comb begin
    cg_cand = ext_score(cell_i.cg_old) - ext_cfg(cfg_i.ext);
    cg_max  = ext_score(cell_i.up);
    if (cell_i.cg_valid && (cg_cand > cg_max)) begin
      cg_max = cg_cand;
    end
    rg_cand = ext_score(cell_i.rg_old) - ext_cfg(cfg_i.ext);
    rg_max  = ext_score(cell_i.left);
    if (cell_i.rg_valid && (rg_cand > rg_max)) begin
      rg_max = rg_cand;
    end

    if (cell_i.sym_eq) begin
      diag_sum = ext_score(cell_i.diag) + ext_cfg(cfg_i.match);
    end else begin
      diag_sum = ext_score(cell_i.diag) - ext_cfg(cfg_i.mism);
    end
    cg_term = cg_max - ext_cfg(cfg_i.open);
    rg_term = rg_max - ext_cfg(cfg_i.open);

    best = '0;
    if (diag_sum > best) begin
      best = diag_sum;
    end
    if (cg_term > best) begin
      best = cg_term;
    end
    if (rg_term > best) begin
      best = rg_term;
    end
    if (best > ext_score(CELL_MAX)) begin
      best = ext_score(CELL_MAX);
    end

    cell_o.h  = best[SCORE_W-1:0];
    cell_o.cg = cg_max[SCORE_W-1:0];
    cell_o.rg = rg_max[SCORE_W-1:0];
  end

endmodule

>>> design/local_alignment_scorer.sv
// Top level of the local alignment scorer: load sequencer, matrix sweep and result register.
//
// Input channel (in_valid_i / in_stall_o): each transfer carries one symbol.
// opcode 0 appends it to the query, opcode 1 to the reference; symbols past
// MAX_LEN are dropped and flagged. A reference symbol with last set starts
// scoring.
// Scoring sweeps the matrix row by row through one shared cell unit. Each
// cell passes through a RAM read state and then a compute and write-back
// state; a job with an empty sequence goes from the start state straight
// to the result. The previous row and column gap values live in two RAMs
// of MAX_LEN entries.
// Output channel (out_valid_o / out_stall_i): one result per job with the
// bottom-right cell, the best cell and the overflow flag. While scoring and
// while the result waits, in_stall_o stays high; a stalled result holds.
// Once the result transfers, both lengths and the overflow flag clear.
// Reset clears lengths, flags and the sequencer and loads the score
// registers with match 2, mismatch 1, gap open 1, gap extend 1; the
// RAMs need no clearing.
module local_alignment_scorer #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lasc_pkg::CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [lasc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [lasc_pkg::SYM_W-1:0]    symbol_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lasc_pkg::SCORE_W-1:0]  end_score_o,
  output logic [lasc_pkg::SCORE_W-1:0]  best_score_o,
  output logic                          overflow_o
);
  import lasc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_CALC,
    ST_OUT
  } state_e;

  state_e             state_q, state_d;
  score_cfg_t         cfg_q, cfg_d;
  logic [LW-1:0]      qlen_q, qlen_d;
  logic [LW-1:0]      rlen_q, rlen_d;
  logic               ovf_q, ovf_d;
  logic [AW-1:0]      row_q, row_d;
  logic [AW-1:0]      col_q, col_d;
  logic [SCORE_W-1:0] diag_q, diag_d;
  logic [SCORE_W-1:0] left_q, left_d;
  logic [SCORE_W-1:0] rg_q, rg_d;
  logic [SCORE_W-1:0] best_q, best_d;
  logic [SCORE_W-1:0] end_q, end_d;

  logic               in_acc;
  logic               out_acc;
  logic               q_we;
  logic               r_we;
  logic               cell_we;
  logic [SYM_W-1:0]   q_sym;
  logic [SYM_W-1:0]   r_sym;
  logic [SCORE_W-1:0] h_up;
  logic [SCORE_W-1:0] cg_rd;
  logic [LW-1:0]      qlen_m1;
  logic [LW-1:0]      rlen_m1;
  cell_in_t           cell_in;
  cell_out_t          cell_out;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  assign q_we    = in_acc && (opcode_i == OP_QUERY) && (qlen_q < LEN_MAX);
  assign r_we    = in_acc && (opcode_i == OP_REF) && (rlen_q < LEN_MAX);
  assign cell_we = (state_q == ST_CALC);
  assign qlen_m1 = qlen_q - LW'(1);
  assign rlen_m1 = rlen_q - LW'(1);

  lasc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (qlen_q[AW-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (row_q),
    .rdata_o (q_sym)
  );

  lasc_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (rlen_q[AW-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (col_q),
    .rdata_o (r_sym)
  );

  lasc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (col_q),
    .wdata_i (cell_out.h),
    .raddr_i (col_q),
    .rdata_o (h_up)
  );

  lasc_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN)) u_gap_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (col_q),
    .wdata_i (cell_out.cg),
    .raddr_i (col_q),
    .rdata_o (cg_rd)
  );

  always_comb begin
    cell_in.up       = (row_q == '0) ? '0 : h_up;
    cell_in.diag     = (col_q == '0) ? '0 : diag_q;
    cell_in.left     = (col_q == '0) ? '0 : left_q;
    cell_in.cg_old   = cg_rd;
    cell_in.cg_valid = (row_q != '0);
    cell_in.rg_old   = rg_q;
    cell_in.rg_valid = (col_q != '0);
    cell_in.sym_eq   = (q_sym == r_sym);
  end

  lasc_cell_unit u_cell (
    .cell_i (cell_in),
    .cfg_i  (cfg_q),
    .cell_o (cell_out)
  );

  always_comb begin
    state_d = state_q;
    cfg_d   = cfg_q;
    qlen_d  = qlen_q;
    rlen_d  = rlen_q;
    ovf_d   = ovf_q;
    row_d   = row_q;
    col_d   = col_q;
    diag_d  = diag_q;
    left_d  = left_q;
    rg_d    = rg_q;
    best_d  = best_q;
    end_d   = end_q;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MATCH:    cfg_d.match = cfg_wdata_i;
        REG_MISMATCH: cfg_d.mism  = cfg_wdata_i;
        REG_GAP_OPEN: cfg_d.open  = cfg_wdata_i;
        REG_GAP_EXT:  cfg_d.ext   = cfg_wdata_i;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_QUERY) begin
            if (qlen_q < LEN_MAX) begin
              qlen_d = qlen_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            if (rlen_q < LEN_MAX) begin
              rlen_d = rlen_q + LW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            if (last_i) begin
              state_d = ST_START;
            end
          end
        end
      end
      ST_START: begin
        best_d = '0;
        end_d  = '0;
        row_d  = '0;
        col_d  = '0;
        if ((qlen_q == '0) || (rlen_q == '0)) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        diag_d = cell_in.up;
        left_d = cell_out.h;
        rg_d   = cell_out.rg;
        if (cell_out.h > best_q) begin
          best_d = cell_out.h;
        end
        if (col_q == rlen_m1[AW-1:0]) begin
          col_d = '0;
          if (row_q == qlen_m1[AW-1:0]) begin
            end_d   = cell_out.h;
            state_d = ST_OUT;
          end else begin
            row_d   = row_q + AW'(1);
            state_d = ST_RD;
          end
        end else begin
          col_d   = col_q + AW'(1);
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          qlen_d  = '0;
          rlen_d  = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= '{match: CFG_W'(2), mism: CFG_W'(1), open: CFG_W'(1), ext: CFG_W'(1)};
      qlen_q    <= '0;
      rlen_q    <= '0;
      ovf_q     <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
    end else begin
      state_q   <= state_d;
      cfg_q     <= cfg_d;
      qlen_q    <= qlen_d;
      rlen_q    <= rlen_d;
      ovf_q     <= ovf_d;
      row_q     <= row_d;
      col_q     <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q <= diag_d;
    left_q <= left_d;
    rg_q   <= rg_d;
    best_q <= best_d;
    end_q  <= end_d;
  end

  assign end_score_o  = end_q;
  assign best_score_o = best_q;
  assign overflow_o   = ovf_q;

  a_no_load_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input transfer possible while a result is pending");

  a_best_covers_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_score_o >= end_score_o))
    else $error("best score below end score");

  a_sweep_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> ((LW'(col_q) < rlen_q) && (LW'(row_q) < qlen_q)))
    else $error("cell index outside the loaded sequences");

  a_last_starts_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (opcode_i == OP_REF) && last_i) |=> (state_q == ST_START))
    else $error("final reference symbol did not start scoring");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for local_alignment_scorer: symbol streams scored by a matrix predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lasc_pkg::*;

  localparam int MAX_LEN    = 256;
  localparam int IDLE_LIMIT = 524288;
  localparam int GAP_FLOOR  = -(1 << 29);

  typedef struct packed {
    logic             opcode;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } sym_xfer_t;

  typedef struct packed {
    logic [SCORE_W-1:0] end_score;
    logic [SCORE_W-1:0] best_score;
    logic               overflow;
  } job_score_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i  = REG_MATCH;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 opcode_i    = OP_QUERY;
  logic [SYM_W-1:0]     symbol_i    = '0;
  logic                 last_i      = 1'b0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [SCORE_W-1:0]   end_score_o;
  logic [SCORE_W-1:0]   best_score_o;
  logic                 overflow_o;

  sym_xfer_t  pending_syms[$];
  job_score_t expected_scores[$];

  score_cfg_t       scoring = '{6'd2, 6'd1, 6'd1, 6'd1};
  logic [SYM_W-1:0] query_mem[MAX_LEN];
  logic [SYM_W-1:0] ref_mem[MAX_LEN];
  logic [8:0]       q_len = '0;
  logic [8:0]       r_len = '0;
  logic             ovf_seen = 1'b0;

  int fail_count   = 0;
  int idle_cycles  = 0;
  int send_gap_pct = 0;
  int send_idle    = 0;
  int stall_pct    = 0;
  int stall_idle   = 0;

  local_alignment_scorer #(.MAX_LEN(MAX_LEN)) dut (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic int pick_max(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic job_score_t align_score();
    int prev_row[MAX_LEN+1];
    int cur_row[MAX_LEN+1];
    int col_gap[MAX_LEN+1];
    int row_gap;
    int sub;
    int h;
    int best;
    job_score_t res;
    best = 0;
    for (int j = 0; j <= MAX_LEN; j++) begin
      prev_row[j] = 0;
      cur_row[j]  = 0;
      col_gap[j]  = GAP_FLOOR;
    end
    for (int i = 1; i <= int'(q_len); i++) begin
      cur_row[0] = 0;
      row_gap = GAP_FLOOR;
      for (int j = 1; j <= int'(r_len); j++) begin
        col_gap[j] = pick_max(prev_row[j], col_gap[j] - int'(scoring.ext));
        row_gap = pick_max(cur_row[j-1], row_gap - int'(scoring.ext));
        sub = (query_mem[i-1] == ref_mem[j-1]) ? int'(scoring.match) : -int'(scoring.mism);
        h = pick_max(0, prev_row[j-1] + sub);
        h = pick_max(h, col_gap[j] - int'(scoring.open));
        h = pick_max(h, row_gap - int'(scoring.open));
        if (h > int'(CELL_MAX)) h = int'(CELL_MAX);
        cur_row[j] = h;
        if (h > best) best = h;
      end
      prev_row = cur_row;
    end
    res.end_score  = SCORE_W'(prev_row[r_len]);
    res.best_score = SCORE_W'(best);
    res.overflow   = ovf_seen;
    return res;
  endfunction

  function automatic void track_symbol(logic op, logic [SYM_W-1:0] sym, logic fin);
    if (op == OP_QUERY) begin
      if (q_len < MAX_LEN) begin
        query_mem[q_len[7:0]] = sym;
        q_len++;
      end else begin
        ovf_seen = 1'b1;
      end
    end else begin
      if (r_len < MAX_LEN) begin
        ref_mem[r_len[7:0]] = sym;
        r_len++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (fin) begin
        expected_scores.push_back(align_score());
        q_len = '0;
        r_len = '0;
        ovf_seen = 1'b0;
      end
    end
  endfunction

  function automatic void flag_mismatch(string what, int want, int got);
    fail_count++;
    if (fail_count <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endfunction

  // drive input transfers from the pending queue
  always @(posedge clk_i) begin : driver
    sym_xfer_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_idle > 0) begin
        send_idle--;
        in_valid_i <= 1'b0;
      end else if (pending_syms.size() != 0 && int'($urandom_range(0, 99)) < send_gap_pct) begin
        send_idle = $urandom_range(0, 3);
        in_valid_i <= 1'b0;
      end else if (pending_syms.size() != 0) begin
        item = pending_syms.pop_front();
        in_valid_i <= 1'b1;
        opcode_i   <= item.opcode;
        symbol_i   <= item.symbol;
        last_i     <= item.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_idle > 0) begin
      stall_idle--;
      out_stall_i <= 1'b1;
    end else if (int'($urandom_range(0, 99)) < stall_pct) begin
      stall_idle = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : monitor
    job_score_t want;
    logic moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (expected_scores.size() == 0) begin
          flag_mismatch("unexpected result, end_score", 0, int'(end_score_o));
        end else begin
          want = expected_scores.pop_front();
          if (end_score_o !== want.end_score)
            flag_mismatch("end_score", int'(want.end_score), int'(end_score_o));
          if (best_score_o !== want.best_score)
            flag_mismatch("best_score", int'(want.best_score), int'(best_score_o));
          if (overflow_o !== want.overflow)
            flag_mismatch("overflow", int'(want.overflow), int'(overflow_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        track_symbol(opcode_i, symbol_i, last_i);
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic void push_sym(logic op, logic [SYM_W-1:0] sym, logic fin);
    pending_syms.push_back('{op, sym, fin});
  endfunction

  // random content over an alphabet of the given number of symbols
  function automatic void queue_job(int n_query, int n_ref, int kinds);
    logic [SYM_W-1:0] alphabet[4];
    foreach (alphabet[k]) alphabet[k] = SYM_W'($urandom);
    for (int i = 0; i < n_query; i++)
      push_sym(OP_QUERY, alphabet[$urandom_range(0, kinds - 1)], $urandom_range(0, 3) == 0);
    for (int j = 0; j < n_ref; j++)
      push_sym(OP_REF, alphabet[$urandom_range(0, kinds - 1)], j == n_ref - 1);
  endfunction

  function automatic void random_jobs(int target);
    int n;
    int m;
    int count;
    count = 0;
    while (count < target) begin
      n = $urandom_range(0, 5);
      m = $urandom_range(1, 5);
      queue_job(n, m, $urandom_range(1, 4));
      count += n + m;
    end
  endfunction

  task automatic settle();
    while (pending_syms.size() != 0 || in_valid_i || expected_scores.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_scoring(score_cfg_t c);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_MATCH;
    cfg_wdata_i <= c.match;
    @(posedge clk_i);
    cfg_addr_i  <= REG_MISMATCH;
    cfg_wdata_i <= c.mism;
    @(posedge clk_i);
    cfg_addr_i  <= REG_GAP_OPEN;
    cfg_wdata_i <= c.open;
    @(posedge clk_i);
    cfg_addr_i  <= REG_GAP_EXT;
    cfg_wdata_i <= c.ext;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scoring = c;
    @(negedge clk_i);
  endtask

  task automatic set_idling(int gap_pct, int stall_chance);
    send_gap_pct = gap_pct;
    stall_pct    = stall_chance;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(20, 20);
    push_sym(OP_REF, 8'h00, 1'b1);
    push_sym(OP_QUERY, 8'h00, 1'b1);
    push_sym(OP_QUERY, 8'hFF, 1'b0);
    push_sym(OP_REF, 8'hFF, 1'b0);
    push_sym(OP_REF, 8'h00, 1'b1);
    push_sym(OP_QUERY, 8'h5A, 1'b0);
    push_sym(OP_QUERY, 8'hA5, 1'b0);
    push_sym(OP_QUERY, 8'h5A, 1'b0);
    push_sym(OP_REF, 8'h5A, 1'b0);
    push_sym(OP_REF, 8'hA5, 1'b0);
    push_sym(OP_REF, 8'h5A, 1'b1);
    push_sym(OP_QUERY, 8'h11, 1'b0);
    push_sym(OP_QUERY, 8'h22, 1'b0);
    push_sym(OP_QUERY, 8'h33, 1'b0);
    push_sym(OP_QUERY, 8'h44, 1'b0);
    push_sym(OP_REF, 8'h11, 1'b0);
    push_sym(OP_REF, 8'h22, 1'b0);
    push_sym(OP_REF, 8'h44, 1'b1);
    push_sym(OP_QUERY, 8'h11, 1'b0);
    push_sym(OP_QUERY, 8'h22, 1'b0);
    push_sym(OP_QUERY, 8'h44, 1'b0);
    push_sym(OP_REF, 8'h11, 1'b0);
    push_sym(OP_REF, 8'h22, 1'b0);
    push_sym(OP_REF, 8'h33, 1'b0);
    push_sym(OP_REF, 8'h44, 1'b1);

    set_scoring('{6'd0, 6'd0, 6'd0, 6'd0});
    set_idling($urandom_range(0, 40), $urandom_range(0, 40));
    random_jobs(20);

    set_scoring('{6'd63, 6'd63, 6'd63, 6'd63});
    set_idling($urandom_range(0, 40), $urandom_range(0, 40));
    random_jobs(20);

    set_scoring(score_cfg_t'(24'($urandom_range(0, 24'hFFFFFF))));
    set_idling($urandom_range(0, 40), $urandom_range(0, 40));
    random_jobs(15);

    set_scoring('{6'd63, 6'd0, 6'd0, 6'd0});
    queue_job(MAX_LEN + 1, MAX_LEN + 1, 1);
    random_jobs(15);

    set_idling(0, 0);
    set_scoring(score_cfg_t'(24'($urandom_range(0, 24'hFFFFFF))));
    random_jobs(25);

    settle();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
